@@ sv/opsp_pkg.sv @@
// Shared types, character codes and digit helpers for the option symbol parser.
package opsp_pkg;

   localparam int PrefixLen = 2;
   localparam int TailLen   = 15;
   localparam int RootBytes = 8;

   localparam logic [7:0] CharO     = 8'h4F;
   localparam logic [7:0] CharColon = 8'h3A;
   localparam logic [7:0] CharCall  = 8'h43;
   localparam logic [7:0] CharPut   = 8'h50;
   localparam logic [7:0] CharZero  = 8'h30;
   localparam logic [7:0] CharNine  = 8'h39;

   localparam logic [5:0] CountMax  = 6'd63;

   typedef enum logic [2:0] {
      STATUS_OK,
      STATUS_BAD_PREFIX,
      STATUS_TOO_SHORT,
      STATUS_STRIKE_NONDIGIT,
      STATUS_BAD_TYPE,
      STATUS_DATE_NONDIGIT,
      STATUS_ROOT_TOO_LONG
   } status_type;

   typedef struct packed {
      logic [7:0] symbol_byte;
      logic       last_byte;
   } req_payload_type;

   typedef struct packed {
      status_type  status;
      logic        is_put;
      logic [6:0]  year_two_digit;
      logic [6:0]  month_value;
      logic [6:0]  day_value;
      logic [26:0] strike_thousandths;
      logic [3:0]  root_length;
      logic [63:0] root_packed;
   } rsp_payload_type;

   typedef struct packed {
      logic       valid;
      logic [5:0] length;
      logic       prefix_good;
   } pend_type;

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= CharZero) && (c <= CharNine);
   endfunction

   function automatic logic [6:0] two_digits(input logic [7:0] hi, input logic [7:0] lo);
      return {3'b000, hi[3:0]} * 7'd10 + {3'b000, lo[3:0]};
   endfunction

   function automatic logic [13:0] four_digits(input logic [7:0] d3, input logic [7:0] d2,
                                                input logic [7:0] d1, input logic [7:0] d0);
      return {10'd0, d3[3:0]} * 14'd1000 + {10'd0, d2[3:0]} * 14'd100
           + {10'd0, d1[3:0]} * 14'd10 + {10'd0, d0[3:0]};
   endfunction

endpackage

@@ sv/opsp_window.sv @@
// Byte count, prefix tracking, shift window and pending-symbol register.
module opsp_window #(
   parameter int WindowDepth = 23
) (
   input  logic                              clock,
   input  logic                              reset,
   input  opsp_pkg::req_payload_type         req_payload,
   input  logic                              accept,
   input  logic                              advance,
   output logic [WindowDepth-1:0][7:0]       window,
   output opsp_pkg::pend_type                pend
);
   import opsp_pkg::*;

   logic [5:0]                   count_ff, count_in;
   logic                         prefix_ff, prefix_in;
   logic [WindowDepth-1:0][7:0]  window_ff;
   pend_type                     pend_ff, pend_in;
   logic [5:0]                   len;
   logic                         prefix_upd;

   always_comb begin
      len = (count_ff == CountMax) ? CountMax : count_ff + 6'd1;
      if (count_ff == 6'd0) begin
         prefix_upd = (req_payload.symbol_byte == CharO);
      end else if (count_ff == 6'd1) begin
         prefix_upd = prefix_ff && (req_payload.symbol_byte == CharColon);
      end else begin
         prefix_upd = prefix_ff;
      end
   end

   always_comb begin
      count_in  = count_ff;
      prefix_in = prefix_ff;
      pend_in   = pend_ff;
      if (advance) begin
         pend_in.valid = 1'b0;
      end
      if (accept) begin
         if (req_payload.last_byte) begin
            count_in            = 6'd0;
            prefix_in           = 1'b0;
            pend_in.valid       = 1'b1;
            pend_in.length      = len;
            pend_in.prefix_good = prefix_upd;
         end else begin
            count_in  = len;
            prefix_in = prefix_upd;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= 6'd0;
         prefix_ff     <= 1'b0;
         pend_ff.valid <= 1'b0;
      end else begin
         count_ff      <= count_in;
         prefix_ff     <= prefix_in;
         pend_ff.valid <= pend_in.valid;
      end
      pend_ff.length      <= pend_in.length;
      pend_ff.prefix_good <= pend_in.prefix_good;
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         window_ff <= {window_ff[WindowDepth-2:0], req_payload.symbol_byte};
      end
   end

   assign window = window_ff;
   assign pend   = pend_ff;

endmodule

@@ sv/opsp_decode.sv @@
// Field checks and decoding of a complete symbol held in the window.
module opsp_decode #(
   parameter int MaxRoot     = 8,
   parameter int WindowDepth = 23
) (
   input  logic [WindowDepth-1:0][7:0]  window,
   input  opsp_pkg::pend_type           pend,
   output opsp_pkg::rsp_payload_type    result
);
   import opsp_pkg::*;

   localparam int IdxW = $clog2(WindowDepth);

   logic [5:0]   root_len;
   logic [5:0]   idx;
   logic         strike_ok;
   logic         type_ok;
   logic         date_ok;
   status_type   status;
   logic [13:0]  strike_hi;
   logic [13:0]  strike_lo;
   logic [63:0]  packed_root;

   always_comb begin
      root_len  = pend.length - 6'(PrefixLen + TailLen);
      strike_ok = 1'b1;
      for (int i = 0; i < 8; i++) begin
         strike_ok = strike_ok && is_digit(window[i]);
      end
      type_ok = (window[8] == CharCall) || (window[8] == CharPut);
      date_ok = 1'b1;
      for (int i = 9; i < TailLen; i++) begin
         date_ok = date_ok && is_digit(window[i]);
      end

      if ((pend.length < 6'(PrefixLen)) || !pend.prefix_good) begin
         status = STATUS_BAD_PREFIX;
      end else if (pend.length < 6'(PrefixLen + TailLen)) begin
         status = STATUS_TOO_SHORT;
      end else if (!strike_ok) begin
         status = STATUS_STRIKE_NONDIGIT;
      end else if (!type_ok) begin
         status = STATUS_BAD_TYPE;
      end else if (!date_ok) begin
         status = STATUS_DATE_NONDIGIT;
      end else if (root_len > 6'(MaxRoot)) begin
         status = STATUS_ROOT_TOO_LONG;
      end else begin
         status = STATUS_OK;
      end
   end

   always_comb begin
      packed_root = 64'd0;
      idx         = 6'd0;
      for (int i = 0; i < RootBytes; i++) begin
         idx = 6'(TailLen - 1) + root_len - 6'(i);
         if ((6'(i) < root_len) && (idx < 6'(WindowDepth))) begin
            packed_root[8*i +: 8] = window[idx[IdxW-1:0]];
         end
      end
      strike_hi = four_digits(window[7], window[6], window[5], window[4]);
      strike_lo = four_digits(window[3], window[2], window[1], window[0]);
   end

   always_comb begin
      result        = '0;
      result.status = status;
      if (status == STATUS_OK) begin
         result.is_put             = (window[8] == CharPut);
         result.year_two_digit     = two_digits(window[14], window[13]);
         result.month_value        = two_digits(window[12], window[11]);
         result.day_value          = two_digits(window[10], window[9]);
         result.strike_thousandths = {13'd0, strike_hi} * 27'd10000 + {13'd0, strike_lo};
         result.root_length        = root_len[3:0];
         result.root_packed        = packed_root;
      end
   end

endmodule

@@ sv/option_symbol_parser_top.sv @@
// Option symbol parser top level: byte intake, decode and result register.
//
// Symbol bytes enter one per cycle while req_stall is low, with no gaps
// required; the byte flagged last_byte is marked pending at the edge that
// accepts it, and its result is loaded into the result register, raising
// rsp_valid, once the result register is empty or not stalled. The input is
// stalled only while a finished symbol is pending and the result register
// holds a stalled result. Non-last bytes never produce a result. The window
// holds 15 + MAX_ROOT bytes, enough for the tail and the longest legal root.
module option_symbol_parser_top #(
   parameter int MAX_ROOT = 8
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  opsp_pkg::req_payload_type   req_payload,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output opsp_pkg::rsp_payload_type   rsp_payload
);
   import opsp_pkg::*;

   localparam int WindowDepth = TailLen + MAX_ROOT;

   logic [WindowDepth-1:0][7:0]  window;
   pend_type                     pend;
   rsp_payload_type              result;
   rsp_payload_type              rsp_payload_ff;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic                         accept;
   logic                         advance;

   assign advance   = pend.valid && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = pend.valid && !advance;
   assign accept    = req_valid && !req_stall;

   opsp_window #(
      .WindowDepth(WindowDepth)
   ) u_window (
      .clock      (clock),
      .reset      (reset),
      .req_payload(req_payload),
      .accept     (accept),
      .advance    (advance),
      .window     (window),
      .pend       (pend)
   );

   opsp_decode #(
      .MaxRoot    (MAX_ROOT),
      .WindowDepth(WindowDepth)
   ) u_decode (
      .window(window),
      .pend  (pend),
      .result(result)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_payload_ff <= result;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

@@ sv/opsp_checker.sv @@
// Port-level assertions for the option symbol parser, bound to the top level.
module opsp_checker #(
   parameter int MAX_ROOT = 8
) (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_stall,
   input logic                        rsp_valid,
   input logic                        rsp_stall,
   input opsp_pkg::rsp_payload_type   rsp_payload
);
   import opsp_pkg::*;

   property p_reset_clears;
      @(posedge clock) reset |=> !rsp_valid;
   endproperty
   a_reset_clears: assert property (p_reset_clears)
      else $error("result valid after reset");

   property p_hold_stalled;
      @(posedge clock) disable iff (reset)
         (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_payload));
   endproperty
   a_hold_stalled: assert property (p_hold_stalled)
      else $error("stalled result changed");

   property p_stall_needs_held_result;
      @(posedge clock) disable iff (reset)
         req_stall |-> (rsp_valid && rsp_stall);
   endproperty
   a_stall_needs_held_result: assert property (p_stall_needs_held_result)
      else $error("input stalled with no held result");

   property p_error_zero;
      @(posedge clock) disable iff (reset)
         (rsp_valid && (rsp_payload.status != STATUS_OK)) |->
         (!rsp_payload.is_put && (rsp_payload.year_two_digit == 7'd0)
          && (rsp_payload.strike_thousandths == 27'd0)
          && (rsp_payload.root_length == 4'd0) && (rsp_payload.root_packed == 64'd0));
   endproperty
   a_error_zero: assert property (p_error_zero)
      else $error("error result carries nonzero fields");

   property p_ok_ranges;
      @(posedge clock) disable iff (reset)
         (rsp_valid && (rsp_payload.status == STATUS_OK)) |->
         ((rsp_payload.root_length <= 4'(MAX_ROOT))
          && (rsp_payload.year_two_digit <= 7'd99) && (rsp_payload.month_value <= 7'd99)
          && (rsp_payload.day_value <= 7'd99)
          && (rsp_payload.strike_thousandths <= 27'd99999999));
   endproperty
   a_ok_ranges: assert property (p_ok_ranges)
      else $error("decoded field out of range");

endmodule

bind option_symbol_parser_top opsp_checker #(.MAX_ROOT(MAX_ROOT)) u_checker (.*);
